// ===== rtl/core/tamj_pkg.sv =====
// tamj_pkg: payload types and register indexes of the triangle affine map block
// no dependencies; used by triangle_affine_map_jacobian
package tamj_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERTEX0_X = 3'd0,
    CFG_VERTEX0_Y = 3'd1,
    CFG_VERTEX1_X = 3'd2,
    CFG_VERTEX1_Y = 3'd3,
    CFG_VERTEX2_X = 3'd4,
    CFG_VERTEX2_Y = 3'd5,
    CFG_DEGEN_LIM = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] ref_xi;
    logic signed [31:0] ref_eta;
    logic signed [31:0] grad_ref_xi;
    logic signed [31:0] grad_ref_eta;
  } in_t;

  typedef struct packed {
    logic signed [31:0] phys_x;
    logic signed [31:0] phys_y;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [47:0] jac_det;
    logic        [45:0] elem_area;
    logic               degenerate;
  } out_t;

endpackage

// ===== rtl/core/triangle_affine_map_jacobian.sv =====
// triangle_affine_map_jacobian: linear triangle mapping, jacobian and physical gradient
// depends on tamj_pkg for payload types and register indexes
// throughput: one item per cycle while the output is not stalled
// the gradient divider is a 33-stage restoring pipeline, one quotient bit per stage
// a stalled output freezes the whole pipeline; no bubbles are lost or duplicated
// reset clears all valid bits and loads the unit triangle with a zero degenerate limit
module triangle_affine_map_jacobian #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tamj_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tamj_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tamj_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tamj_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int SW  = 67;              // exact sums with 2F fraction bits
  localparam int DMW = SW - FRAC_BITS;  // rounded determinant magnitude
  localparam int QB  = 33;              // quotient bits kept before saturation
  localparam int RW  = DMW + QB;        // divider remainder width
  localparam int NST = QB + 2;          // round stage, overflow stage, divider stages
  localparam int NV  = NST + 2;

  localparam logic signed [SW-1:0] Max32 = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] Min32 = ~Max32;
  localparam logic signed [SW-1:0] Max48 = (SW'(1) << 47) - SW'(1);
  localparam logic signed [SW-1:0] Min48 = ~Max48;
  localparam logic signed [SW-1:0] Half  = SW'(1) << (FRAC_BITS - 1);
  localparam logic [RW-1:0]        AreaMax = RW'(46'h3fff_ffff_ffff);
  localparam logic [QB-1:0]        QPosMax = QB'(32'h7fff_ffff);
  localparam logic [QB-1:0]        QNegMax = QB'(32'h8000_0000);

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [64:0] xa;
    logic signed [64:0] eb;
    logic signed [64:0] xc;
    logic signed [64:0] ed;
    logic signed [65:0] ad;
    logic signed [65:0] bc;
    logic signed [64:0] dg;
    logic signed [64:0] cg;
    logic signed [64:0] ag;
    logic signed [64:0] bg;
  } mul_t;

  typedef struct packed {
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] det;
    logic signed [SW-1:0] nx;
    logic signed [SW-1:0] ny;
  } sum_t;

  typedef struct packed {
    logic [31:0]    phys_x;
    logic [31:0]    phys_y;
    logic [47:0]    det;
    logic [45:0]    area;
    logic           degen;
    logic           neg_x;
    logic           neg_y;
    logic           ov_x;
    logic           ov_y;
    logic [DMW-1:0] dmag;
    logic [RW-1:0]  rem_x;
    logic [RW-1:0]  rem_y;
    logic [QB-1:0]  q_x;
    logic [QB-1:0]  q_y;
  } div_t;

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic [31:0] r;
    if (v > Max32) begin
      r = 32'h7fff_ffff;
    end else if (v < Min32) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [SW-1:0] v);
    logic [47:0] r;
    if (v > Max48) begin
      r = {1'b0, {47{1'b1}}};
    end else if (v < Min48) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] quot32(input logic [QB-1:0] q, input logic ov,
                                         input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (ov || q > QNegMax) ? 32'h8000_0000 : 32'(-q[31:0]);
    end else begin
      r = (ov || q > QPosMax) ? 32'h7fff_ffff : q[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [31:0] v0x_q, v0y_q, v1x_q, v1y_q, v2x_q, v2y_q;
  logic [15:0]        limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0x_q   <= '0;
      v0y_q   <= '0;
      v1x_q   <= 32'(1) << FRAC_BITS;
      v1y_q   <= '0;
      v2x_q   <= '0;
      v2y_q   <= 32'(1) << FRAC_BITS;
      limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tamj_pkg::cfg_idx_e'(cfg_index_i))
        tamj_pkg::CFG_VERTEX0_X: v0x_q   <= cfg_wdata_i;
        tamj_pkg::CFG_VERTEX0_Y: v0y_q   <= cfg_wdata_i;
        tamj_pkg::CFG_VERTEX1_X: v1x_q   <= cfg_wdata_i;
        tamj_pkg::CFG_VERTEX1_Y: v1y_q   <= cfg_wdata_i;
        tamj_pkg::CFG_VERTEX2_X: v2x_q   <= cfg_wdata_i;
        tamj_pkg::CFG_VERTEX2_Y: v2y_q   <= cfg_wdata_i;
        tamj_pkg::CFG_DEGEN_LIM: limit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // jacobian entries, exact in 33 bits
  logic signed [32:0] ja, jb, jc, jd;
  assign ja = 33'(v1x_q) - 33'(v0x_q);
  assign jb = 33'(v2x_q) - 33'(v0x_q);
  assign jc = 33'(v1y_q) - 33'(v0y_q);
  assign jd = 33'(v2y_q) - 33'(v0y_q);

  logic en;
  logic out_valid_q;
  logic [NV-1:0] vld_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: products, operands widened so the full product is kept
  mul_t mul_d, mul_q;
  always_comb begin
    mul_d.x0 = v0x_q;
    mul_d.y0 = v0y_q;
    mul_d.xa = 65'(in_data_i.ref_xi) * 65'(ja);
    mul_d.eb = 65'(in_data_i.ref_eta) * 65'(jb);
    mul_d.xc = 65'(in_data_i.ref_xi) * 65'(jc);
    mul_d.ed = 65'(in_data_i.ref_eta) * 65'(jd);
    mul_d.ad = 66'(ja) * 66'(jd);
    mul_d.bc = 66'(jb) * 66'(jc);
    mul_d.dg = 65'(jd) * 65'(in_data_i.grad_ref_xi);
    mul_d.cg = 65'(jc) * 65'(in_data_i.grad_ref_eta);
    mul_d.ag = 65'(ja) * 65'(in_data_i.grad_ref_eta);
    mul_d.bg = 65'(jb) * 65'(in_data_i.grad_ref_xi);
  end

  // stage 2: exact sums
  sum_t sum_d, sum_q;
  always_comb begin
    sum_d.sx  = (SW'(mul_q.x0) <<< FRAC_BITS) + SW'(mul_q.xa) + SW'(mul_q.eb);
    sum_d.sy  = (SW'(mul_q.y0) <<< FRAC_BITS) + SW'(mul_q.xc) + SW'(mul_q.ed);
    sum_d.det = SW'(mul_q.ad) - SW'(mul_q.bc);
    sum_d.nx  = SW'(mul_q.dg) - SW'(mul_q.cg);
    sum_d.ny  = SW'(mul_q.ag) - SW'(mul_q.bg);
  end

  div_t st_d [NST];
  div_t st_q [NST];

  // stage 3: rounding, point saturation, magnitudes
  logic signed [SW-1:0] rx, ry, rdet, mdet;
  always_comb begin
    rx   = (sum_q.sx + Half) >>> FRAC_BITS;
    ry   = (sum_q.sy + Half) >>> FRAC_BITS;
    rdet = (sum_q.det + Half) >>> FRAC_BITS;
    mdet = rdet[SW-1] ? -rdet : rdet;
    st_d[0]        = '0;
    st_d[0].phys_x = sat32(rx);
    st_d[0].phys_y = sat32(ry);
    st_d[0].det    = sat48(rdet);
    st_d[0].dmag   = mdet[DMW-1:0];
    st_d[0].neg_x  = sum_q.nx[SW-1] ^ rdet[SW-1];
    st_d[0].neg_y  = sum_q.ny[SW-1] ^ rdet[SW-1];
    st_d[0].rem_x  = RW'(sum_q.nx[SW-1] ? -sum_q.nx : sum_q.nx);
    st_d[0].rem_y  = RW'(sum_q.ny[SW-1] ? -sum_q.ny : sum_q.ny);
  end

  // stage 4: degenerate test, area, quotient overflow
  logic [RW-1:0] dtop, area_w;
  always_comb begin
    dtop          = RW'(st_q[0].dmag) << QB;
    area_w        = RW'(st_q[0].dmag >> 1);
    st_d[1]       = st_q[0];
    st_d[1].degen = st_q[0].dmag <= DMW'(limit_q);
    st_d[1].area  = (area_w > AreaMax) ? AreaMax[45:0] : area_w[45:0];
    st_d[1].ov_x  = st_q[0].rem_x >= dtop;
    st_d[1].ov_y  = st_q[0].rem_y >= dtop;
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [RW-1:0] dsh;
    always_comb begin
      dsh       = RW'(st_q[j+1].dmag) << K;
      st_d[j+2] = st_q[j+1];
      if (!st_q[j+1].ov_x && st_q[j+1].rem_x >= dsh) begin
        st_d[j+2].rem_x = st_q[j+1].rem_x - dsh;
        st_d[j+2].q_x[K] = 1'b1;
      end
      if (!st_q[j+1].ov_y && st_q[j+1].rem_y >= dsh) begin
        st_d[j+2].rem_y = st_q[j+1].rem_y - dsh;
        st_d[j+2].q_y[K] = 1'b1;
      end
    end
  end

  // output stage: sign, saturation, degenerate zeroing
  tamj_pkg::out_t out_d, out_q;
  always_comb begin
    out_d.phys_x     = st_q[NST-1].phys_x;
    out_d.phys_y     = st_q[NST-1].phys_y;
    out_d.jac_det    = st_q[NST-1].det;
    out_d.elem_area  = st_q[NST-1].area;
    out_d.degenerate = st_q[NST-1].degen;
    if (st_q[NST-1].degen) begin
      out_d.grad_x = '0;
      out_d.grad_y = '0;
    end else begin
      out_d.grad_x = quot32(st_q[NST-1].q_x, st_q[NST-1].ov_x, st_q[NST-1].neg_x);
      out_d.grad_y = quot32(st_q[NST-1].q_y, st_q[NST-1].ov_y, st_q[NST-1].neg_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NV-2:0], in_valid_i};
      out_valid_q <= vld_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q <= mul_d;
      sum_q <= sum_d;
      for (int i = 0; i < NST; i++) begin
        st_q[i] <= st_d[i];
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a degenerate element never carries a gradient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.grad_x == '0 && out_data_o.grad_y == '0)
    else $error("degenerate result with nonzero gradient");

  // area is half a non-negative determinant, saturations line up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.jac_det[47] |->
      out_data_o.elem_area == out_data_o.jac_det[46:1])
    else $error("area does not match determinant");

  // the input side only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // a result held under stall keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");

endmodule
